>>> rtl/mdp_pkg.sv
// Shared constants and the stage token type for the min/max decimation pyramid.
package mdp_pkg;

	localparam int MAX_LEVELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LEVEL_BITS = 4;
	localparam logic [LEVEL_BITS-1:0] LEVELS_RESET = 4'd8;

	// Control part of the word that moves from one level cell to the next.
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [1:0] cnt;
	} tok_t;

endpackage

>>> rtl/mdp_cell.sv
// One decimation level: group state plus the pipeline stage that feeds the next level.
module mdp_cell #(
	parameter int MAX_LEVELS = mdp_pkg::MAX_LEVELS_DEF,
	parameter int SAMPLE_BITS = mdp_pkg::SAMPLE_BITS_DEF,
	parameter int LEVEL = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mdp_pkg::LEVEL_BITS-1:0]       levels_in_use,
	input  mdp_pkg::tok_t                        tok_in,
	input  logic signed [SAMPLE_BITS-1:0]        vals_in [2],
	input  logic [2*MAX_LEVELS-1:0]              mask_in,
	input  logic signed [SAMPLE_BITS-1:0]        res_in [2*MAX_LEVELS],
	output logic                                 take,
	input  logic                                 next_take,
	output mdp_pkg::tok_t                        tok_out,
	output logic signed [SAMPLE_BITS-1:0]        vals_out [2],
	output logic [2*MAX_LEVELS-1:0]              mask_out,
	output logic signed [SAMPLE_BITS-1:0]        res_out [2*MAX_LEVELS]
);

	localparam int LW = mdp_pkg::LEVEL_BITS + 1;
	localparam int SLOT = 2 * (LEVEL - 1);

	logic [1:0]                   fill_q;
	logic signed [SAMPLE_BITS-1:0] low_q;
	logic signed [SAMPLE_BITS-1:0] high_q;
	logic                         hwl_q;

	logic                         valid_q;
	logic                         last_q;
	logic [1:0]                   cnt_q;
	logic signed [SAMPLE_BITS-1:0] val_q [2];
	logic [2*MAX_LEVELS-1:0]      mask_q;
	logic signed [SAMPLE_BITS-1:0] res_q [2*MAX_LEVELS];

	logic                         in_use;
	logic                         active;
	logic                         load;
	logic [1:0]                   fill_n;
	logic signed [SAMPLE_BITS-1:0] low_n;
	logic signed [SAMPLE_BITS-1:0] high_n;
	logic                         hwl_n;
	logic [1:0]                   emit_n;
	logic signed [SAMPLE_BITS-1:0] emit_v [2];
	logic [2*MAX_LEVELS-1:0]      mask_d;
	logic signed [SAMPLE_BITS-1:0] res_d [2*MAX_LEVELS];

	assign in_use = {1'b0, levels_in_use} >= LW'(LEVEL);
	assign active = in_use && (tok_in.cnt != 2'd0);
	assign take = !valid_q || next_take;
	assign load = tok_in.valid && take;

	// Feed up to two values in order, then flush the partial group on a record end.
	always_comb begin
		fill_n = fill_q;
		low_n = low_q;
		high_n = high_q;
		hwl_n = hwl_q;
		emit_n = 2'd0;
		emit_v[0] = low_q;
		emit_v[1] = high_q;
		for (int i = 0; i < 2; i++) begin
			if (tok_in.cnt > 2'(i)) begin
				if (fill_n == 2'd0) begin
					low_n = vals_in[i];
					high_n = vals_in[i];
					hwl_n = 1'b1;
				end else begin
					if (vals_in[i] < low_n) begin
						low_n = vals_in[i];
						hwl_n = 1'b0;
					end
					if (vals_in[i] > high_n) begin
						high_n = vals_in[i];
						hwl_n = 1'b1;
					end
				end
				if (fill_n == 2'd3) begin
					fill_n = 2'd0;
					emit_n = 2'd2;
					emit_v[0] = hwl_n ? low_n : high_n;
					emit_v[1] = hwl_n ? high_n : low_n;
				end else begin
					fill_n = fill_n + 2'd1;
				end
			end
		end
		if (tok_in.last && emit_n == 2'd0) begin
			if (fill_n == 2'd3) begin
				emit_n = 2'd2;
				emit_v[0] = hwl_n ? low_n : high_n;
				emit_v[1] = hwl_n ? high_n : low_n;
			end else if (fill_n != 2'd0) begin
				emit_n = 2'd1;
				emit_v[0] = low_n;
			end
		end
		if (!active) begin
			emit_n = 2'd0;
		end
	end

	// This level's two result slots are filled in on top of what arrives from below.
	always_comb begin
		mask_d = mask_in;
		res_d = res_in;
		if (active) begin
			mask_d[SLOT] = emit_n != 2'd0;
			mask_d[SLOT+1] = emit_n == 2'd2;
			res_d[SLOT] = emit_v[0];
			res_d[SLOT+1] = emit_v[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (next_take) begin
				valid_q <= 1'b0;
			end
			if (load && tok_in.last) begin
				fill_q <= 2'd0;
			end else if (load && active) begin
				fill_q <= fill_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && active) begin
			low_q <= low_n;
			high_q <= high_n;
			hwl_q <= hwl_n;
		end
		if (load) begin
			last_q <= tok_in.last;
			cnt_q <= emit_n;
			val_q <= emit_v;
			mask_q <= mask_d;
			res_q <= res_d;
		end
	end

	assign tok_out = '{valid: valid_q, last: last_q, cnt: cnt_q};
	assign vals_out = val_q;
	assign mask_out = mask_q;
	assign res_out = res_q;

endmodule

>>> rtl/mdp_serializer.sv
// Holds a sample's results; sends one word per cycle if out_ready, lowest level first.
module mdp_serializer #(
	parameter int MAX_LEVELS = mdp_pkg::MAX_LEVELS_DEF,
	parameter int SAMPLE_BITS = mdp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mdp_pkg::tok_t                        tok_in,
	input  logic [2*MAX_LEVELS-1:0]              mask_in,
	input  logic signed [SAMPLE_BITS-1:0]        res_in [2*MAX_LEVELS],
	output logic                                 take,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mdp_pkg::LEVEL_BITS-1:0]       level,
	output logic signed [SAMPLE_BITS-1:0]        value,
	output logic                                 level_done,
	output logic                                 run_last
);

	localparam int SLOTS = 2 * MAX_LEVELS;
	localparam int IW = $clog2(SLOTS);

	logic [SLOTS-1:0]              mask_q;
	logic signed [SAMPLE_BITS-1:0] res_q [SLOTS];
	logic                          last_q;

	logic [IW-1:0] sel;
	logic [IW-1:0] sel_odd;
	logic [IW:0]   lvl_w;
	logic          single;

	always_comb begin
		sel = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = IW'(i);
			end
		end
	end

	assign sel_odd = sel | IW'(1);
	assign lvl_w = ({1'b0, sel} >> 1) + (IW+1)'(1);
	assign single = (mask_q & (mask_q - SLOTS'(1))) == '0;

	assign out_valid = mask_q != '0;
	assign level = mdp_pkg::LEVEL_BITS'(lvl_w);
	assign value = res_q[sel];
	// At a record end, a level's word is its last if in the odd slot or that slot is empty.
	assign level_done = last_q && (sel[0] || !mask_q[sel_odd]);
	assign run_last = single;
	assign take = !out_valid || (out_ready && single);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (tok_in.valid && take) begin
			mask_q <= mask_in;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_q & (mask_q - SLOTS'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid && take) begin
			res_q <= res_in;
			last_q <= tok_in.last;
		end
	end

endmodule

>>> rtl/minmax_decimation_pyramid_core.sv
// Min/max peak-preserving decimation pyramid: chain of level cells and output serializer.
// A sample goes through each level cell's register, then the serializer's. Throughput: one
// sample per cycle; a sample's results (up to 2*MAX_LEVELS) leave one per cycle through the
// single output port while out_ready is high; the chain stalls only when they back up.
// Reset clears every level's group and sets levels_in_use to 8.
module minmax_decimation_pyramid_core #(
	parameter int MAX_LEVELS = mdp_pkg::MAX_LEVELS_DEF,
	parameter int SAMPLE_BITS = mdp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mdp_pkg::LEVEL_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 record_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mdp_pkg::LEVEL_BITS-1:0]       level,
	output logic signed [SAMPLE_BITS-1:0]        value,
	output logic                                 level_done,
	output logic                                 run_last
);

	localparam int SLOTS = 2 * MAX_LEVELS;

	logic [mdp_pkg::LEVEL_BITS-1:0] levels_q;

	mdp_pkg::tok_t                 tok_c  [MAX_LEVELS+1];
	logic                          take_c [MAX_LEVELS+1];
	logic signed [SAMPLE_BITS-1:0] vals_c [MAX_LEVELS][2];
	logic [SLOTS-1:0]              mask_c [MAX_LEVELS+1];
	logic signed [SAMPLE_BITS-1:0] res_c  [MAX_LEVELS+1][SLOTS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= mdp_pkg::LEVELS_RESET;
		end else if (cfg_valid) begin
			levels_q <= cfg_data;
		end
	end

	// The incoming sample enters level 1 as a one-value word with no results yet.
	assign tok_c[0] = '{valid: in_valid, last: record_end, cnt: 2'd1};
	assign vals_c[0][0] = sample;
	assign vals_c[0][1] = '0;
	assign mask_c[0] = '0;
	assign res_c[0] = '{default: '0};
	assign in_ready = take_c[0];

	for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
		if (k < MAX_LEVELS - 1) begin : g_mid
			mdp_cell #(
				.MAX_LEVELS (MAX_LEVELS),
				.SAMPLE_BITS(SAMPLE_BITS),
				.LEVEL      (k + 1)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.levels_in_use(levels_q),
				.tok_in       (tok_c[k]),
				.vals_in      (vals_c[k]),
				.mask_in      (mask_c[k]),
				.res_in       (res_c[k]),
				.take         (take_c[k]),
				.next_take    (take_c[k+1]),
				.tok_out      (tok_c[k+1]),
				.vals_out     (vals_c[k+1]),
				.mask_out     (mask_c[k+1]),
				.res_out      (res_c[k+1])
			);
		end else begin : g_top
			mdp_cell #(
				.MAX_LEVELS (MAX_LEVELS),
				.SAMPLE_BITS(SAMPLE_BITS),
				.LEVEL      (k + 1)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.levels_in_use(levels_q),
				.tok_in       (tok_c[k]),
				.vals_in      (vals_c[k]),
				.mask_in      (mask_c[k]),
				.res_in       (res_c[k]),
				.take         (take_c[k]),
				.next_take    (take_c[k+1]),
				.tok_out      (tok_c[k+1]),
				.vals_out     (),
				.mask_out     (mask_c[k+1]),
				.res_out      (res_c[k+1])
			);
		end
	end

	mdp_serializer #(
		.MAX_LEVELS (MAX_LEVELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_in    (tok_c[MAX_LEVELS]),
		.mask_in   (mask_c[MAX_LEVELS]),
		.res_in    (res_c[MAX_LEVELS]),
		.take      (take_c[MAX_LEVELS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.value     (value),
		.level_done(level_done),
		.run_last  (run_last)
	);

endmodule
